// File: src/tone_event_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// Tone event sequencer assertion macros
// Shared property wrappers, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TONE_EVENT_SEQUENCER_TOP_ASSERT_SVH
`define TONE_EVENT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication
`define TES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tes_pkg.sv
// ----------------------------------------------------------------------------
// Tone event sequencer package
// Widths, codes, constants and the per-channel voice record.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int SONG_DEPTH   = 1024;
  localparam int ADDR_W       = $clog2(SONG_DEPTH);
  localparam int EVT_LIMIT    = SONG_DEPTH / 4;
  localparam int EVT_CNT_W    = $clog2(EVT_LIMIT) + 1;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int VOL_W    = 8;
  localparam int INCR_W   = 16;
  localparam int FILTER_W = 14;
  localparam int CHNUM_W  = 2;
  localparam int OPC_W    = 6;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = OPC_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ENV   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_NOTE = 1'b1;
  localparam logic [OPC_W-1:0] OPC_SET_ENV_RST   = 6'd0;
  localparam logic [OPC_W-1:0] OPC_PLAY_NOTE_RST = 6'd1;

  localparam logic [FILTER_W-1:0] FILTER_MAX  = 14'd16383;
  localparam logic [FILTER_W-1:0] FILTER_NOTE = 14'd13600;
  localparam logic [FILTER_W-1:0] FILTER_STEP = 14'd8;
  localparam logic [BYTE_W-1:0]   END_DELTA   = 8'hFF;

  typedef struct packed {
    logic [VOL_W-1:0]  start_vol;
    logic [BYTE_W-1:0] env_delta;
    logic [VOL_W-1:0]  volume;
    logic [INCR_W-1:0] incr;
    logic              restart;
  } voice_t;

endpackage

// File: src/tes_stream_if.sv
// ----------------------------------------------------------------------------
// Tone event sequencer channels
// Valid/ready interfaces for input items and per-channel result items.
// ----------------------------------------------------------------------------
interface tes_in_if
  import tes_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] song_address;
  logic [BYTE_W-1:0] song_byte;

  modport source (output valid, output func, output song_address, output song_byte,
                  input ready);
  modport sink   (input valid, input func, input song_address, input song_byte,
                  output ready);
endinterface

interface tes_out_if
  import tes_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CHNUM_W-1:0]  channel_number;
  logic [VOL_W-1:0]    channel_volume;
  logic [INCR_W-1:0]   phase_increment;
  logic                note_restart;
  logic [FILTER_W-1:0] filter_level;
  logic                song_running;
  logic                last_channel;

  modport source (output valid, output channel_number, output channel_volume,
                  output phase_increment, output note_restart, output filter_level,
                  output song_running, output last_channel, input ready);
  modport sink   (input valid, input channel_number, input channel_volume,
                  input phase_increment, input note_restart, input filter_level,
                  input song_running, input last_channel, output ready);
endinterface

// File: src/tone_event_sequencer_top.sv
// ----------------------------------------------------------------------------
// Tone event sequencer top level
// Load writes song memory; start fetches the first delta byte. Tick: envelope update
// of every channel (active song only), event runs through S_EV0..S_EV4, then a read
// and report per channel. One item at a time: the next is taken only back in idle.
// Synchronous reset clears control state and voice valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module tone_event_sequencer_top
  import tes_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  tes_in_if.sink                in_ch,
  tes_out_if.source             out_ch
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_START  = 11'b000_0000_0010,
    S_ENV_RD = 11'b000_0000_0100,
    S_ENV_WR = 11'b000_0000_1000,
    S_EV0    = 11'b000_0001_0000,
    S_EV1    = 11'b000_0010_0000,
    S_EV2    = 11'b000_0100_0000,
    S_EV3    = 11'b000_1000_0000,
    S_EV4    = 11'b001_0000_0000,
    S_OUT_RD = 11'b010_0000_0000,
    S_OUT_WR = 11'b100_0000_0000
  } state_t;

  state_t state;

  // Configuration: opcode matches for the effect byte
  logic [OPC_W-1:0] opc_env;
  logic [OPC_W-1:0] opc_note;

  always_ff @(posedge clk) begin
    if (rst) begin
      opc_env  <= OPC_SET_ENV_RST;
      opc_note <= OPC_PLAY_NOTE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SET_ENV:   opc_env  <= wr_data;
        CFG_PLAY_NOTE: opc_note <= wr_data;
        default: ;
      endcase
    end
  end

  // Scalar song state
  logic [FILTER_W-1:0]  filter;
  logic [BYTE_W-1:0]    next_time;
  logic [BYTE_W-1:0]    tick_time;
  logic [ADDR_W-1:0]    rd_ptr;
  logic                 active;
  logic                 ended;       // song stopped during the current tick
  logic [EVT_CNT_W-1:0] evt_cnt;
  logic [CH_W-1:0]      ch;          // channel sweep counter
  logic [BYTE_W-1:0]    ev_effect;
  logic [BYTE_W-1:0]    ev_lo;
  logic [BYTE_W-1:0]    ev_hi;

  // Song memory: one write port for loads, one registered read port
  logic [BYTE_W-1:0] song_mem [SONG_DEPTH];
  logic              song_we;
  logic              song_re;
  logic [ADDR_W-1:0] song_raddr;
  logic [BYTE_W-1:0] song_q;

  always_ff @(posedge clk) begin
    if (song_we) begin
      song_mem[in_ch.song_address] <= in_ch.song_byte;
    end
    if (song_re) begin
      song_q <= song_mem[song_raddr];
    end
  end

  // Voice memory: one record per channel, read-modify-write as a registered read, then a write back.
  // Entries never written read as zero through their valid bits.
  voice_t            voice_mem [CHANNELS];
  logic [CHANNELS-1:0] voice_vld;
  logic              voice_we;
  logic [CH_W-1:0]   voice_waddr;
  voice_t            voice_wdata;
  logic              voice_re;
  logic [CH_W-1:0]   voice_raddr;
  voice_t            voice_q;
  logic              voice_q_vld;
  voice_t            voice_rd;

  always_ff @(posedge clk) begin
    if (voice_we) begin
      voice_mem[voice_waddr] <= voice_wdata;
    end
    if (voice_re) begin
      voice_q <= voice_mem[voice_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_vld   <= '0;
      voice_q_vld <= 1'b0;
    end else begin
      if (voice_we) begin
        voice_vld[voice_waddr] <= 1'b1;
      end
      if (voice_re) begin
        voice_q_vld <= voice_vld[voice_raddr];
      end
    end
  end

  assign voice_rd = voice_q_vld ? voice_q : '0;

  // Handshake terms
  logic in_acc;
  logic out_free;
  logic out_load;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign out_load    = (state == S_OUT_WR) && out_free;

  // Envelope step: signed delta added to volume, clamped to 0..255
  logic signed [VOL_W+1:0] vol_sum;
  logic [VOL_W-1:0]        vol_clamped;

  assign vol_sum = signed'({2'b00, voice_rd.volume})
                 + signed'({{2{voice_rd.env_delta[BYTE_W-1]}}, voice_rd.env_delta});

  always_comb begin
    if (vol_sum < 0) begin
      vol_clamped = '0;
    end else if (vol_sum > signed'(10'd255)) begin
      vol_clamped = '1;
    end else begin
      vol_clamped = vol_sum[VOL_W-1:0];
    end
  end

  // Filter rise, saturating
  logic [FILTER_W:0]   filter_sum;
  logic [FILTER_W-1:0] filter_sat;

  assign filter_sum = {1'b0, filter} + {1'b0, FILTER_STEP};
  assign filter_sat = (filter_sum > {1'b0, FILTER_MAX}) ? FILTER_MAX
                                                        : filter_sum[FILTER_W-1:0];

  // Event decode, valid in S_EV4 when song_q holds the delta byte
  logic [1:0]           ev_ch;
  logic [OPC_W-1:0]     ev_op;
  logic                 ev_ch_ok;
  logic                 ev_is_env;
  logic                 ev_is_note;
  logic                 ev_end;
  logic [BYTE_W-1:0]    ev_time;
  logic [EVT_CNT_W-1:0] evt_cnt_next;
  logic                 ev_more;

  assign ev_ch        = ev_effect[1:0];
  assign ev_op        = ev_effect[BYTE_W-1:2];
  assign ev_ch_ok     = {1'b0, ev_ch} < 3'(CHANNELS);
  assign ev_is_env    = ev_ch_ok && (ev_op == opc_env);
  assign ev_is_note   = ev_ch_ok && (ev_op != opc_env) && (ev_op == opc_note);
  assign ev_end       = (song_q == END_DELTA);
  assign ev_time      = next_time + song_q;
  assign evt_cnt_next = evt_cnt + EVT_CNT_W'(1);
  assign ev_more      = !ev_end && (ev_time == tick_time)
                        && (evt_cnt_next < EVT_CNT_W'(EVT_LIMIT));

  // Memory port steering
  always_comb begin
    song_we     = in_acc && (in_ch.func == FUNC_LOAD);
    song_re     = 1'b0;
    song_raddr  = rd_ptr;
    voice_re    = 1'b0;
    voice_raddr = ch;
    voice_we    = 1'b0;
    voice_waddr = ch;
    voice_wdata = voice_rd;
    unique case (state)
      S_IDLE: begin
        // start item: fetch the first delta byte
        song_re    = in_acc && (in_ch.func == FUNC_START);
        song_raddr = in_ch.song_address;
      end
      S_ENV_RD: begin
        voice_re = 1'b1;
      end
      S_ENV_WR: begin
        voice_we           = 1'b1;
        voice_wdata.volume = vol_clamped;
      end
      S_EV0, S_EV1, S_EV2: begin
        song_re = 1'b1;
      end
      S_EV3: begin
        // last byte of the event, and the channel record it may touch
        song_re     = 1'b1;
        voice_re    = 1'b1;
        voice_raddr = CH_W'(ev_effect[1:0]);
      end
      S_EV4: begin
        voice_waddr = CH_W'(ev_ch);
        if (ev_is_env) begin
          voice_we              = 1'b1;
          voice_wdata.start_vol = ev_lo;
          voice_wdata.env_delta = ev_hi;
        end else if (ev_is_note) begin
          voice_we            = 1'b1;
          voice_wdata.volume  = voice_rd.start_vol;
          voice_wdata.incr    = {ev_hi, ev_lo};
          voice_wdata.restart = 1'b1;
        end
      end
      S_OUT_RD: begin
        voice_re = 1'b1;
      end
      S_OUT_WR: begin
        // write back with the mark dropped and, after end of song, no increment
        voice_we            = out_load;
        voice_wdata.restart = 1'b0;
        if (ended) begin
          voice_wdata.incr = '0;
        end
      end
      S_START: ;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filter    <= '0;
      next_time <= '0;
      tick_time <= '0;
      rd_ptr    <= '0;
      active    <= 1'b0;
      ended     <= 1'b0;
      evt_cnt   <= '0;
      ch        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.func)
              FUNC_START: begin
                rd_ptr <= in_ch.song_address + ADDR_W'(1);
                state  <= S_START;
              end
              FUNC_TICK: begin
                ch      <= '0;
                evt_cnt <= '0;
                ended   <= 1'b0;
                state   <= active ? S_ENV_RD : S_OUT_RD;
              end
              default: ;  // loads write memory only; unused code is dropped
            endcase
          end
        end
        S_START: begin
          next_time <= tick_time + song_q;
          active    <= 1'b1;
          state     <= S_IDLE;
        end
        S_ENV_RD: begin
          state <= S_ENV_WR;
        end
        S_ENV_WR: begin
          filter <= filter_sat;
          if (ch == CH_LAST) begin
            ch <= '0;
            if (next_time == tick_time) begin
              state <= S_EV0;
            end else begin
              tick_time <= tick_time + BYTE_W'(1);
              state     <= S_OUT_RD;
            end
          end else begin
            ch    <= ch + CH_W'(1);
            state <= S_ENV_RD;
          end
        end
        S_EV0: begin
          rd_ptr <= rd_ptr + ADDR_W'(1);
          state  <= S_EV1;
        end
        S_EV1: begin
          ev_effect <= song_q;
          rd_ptr    <= rd_ptr + ADDR_W'(1);
          state     <= S_EV2;
        end
        S_EV2: begin
          ev_lo  <= song_q;
          rd_ptr <= rd_ptr + ADDR_W'(1);
          state  <= S_EV3;
        end
        S_EV3: begin
          ev_hi  <= song_q;
          rd_ptr <= rd_ptr + ADDR_W'(1);
          state  <= S_EV4;
        end
        S_EV4: begin
          next_time <= ev_time;
          evt_cnt   <= evt_cnt_next;
          if (ev_is_note) begin
            filter <= FILTER_NOTE;
          end
          if (ev_end) begin
            active <= 1'b0;
            ended  <= 1'b1;
          end
          if (ev_more) begin
            state <= S_EV0;
          end else begin
            tick_time <= tick_time + BYTE_W'(1);
            state     <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_WR;
        end
        S_OUT_WR: begin
          if (out_free) begin
            if (ch == CH_LAST) begin
              state <= S_IDLE;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds one result item so the sweep can run ahead
  logic                out_valid;
  logic [CHNUM_W-1:0]  out_chnum;
  logic [VOL_W-1:0]    out_volume;
  logic [INCR_W-1:0]   out_incr;
  logic                out_restart;
  logic [FILTER_W-1:0] out_filter;
  logic                out_running;
  logic                out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chnum   <= CHNUM_W'(ch);
      out_volume  <= voice_rd.volume;
      out_incr    <= ended ? '0 : voice_rd.incr;
      out_restart <= voice_rd.restart;
      out_filter  <= filter;
      out_running <= active;
      out_last    <= (ch == CH_LAST);
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.channel_number  = out_chnum;
  assign out_ch.channel_volume  = out_volume;
  assign out_ch.phase_increment = out_incr;
  assign out_ch.note_restart    = out_restart;
  assign out_ch.filter_level    = out_filter;
  assign out_ch.song_running    = out_running;
  assign out_ch.last_channel    = out_last;

endmodule

// File: src/tes_checker.sv
// ----------------------------------------------------------------------------
// Tone event sequencer checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "tone_event_sequencer_top_assert.svh"

module tes_checker
  import tes_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [INCR_W-1:0] out_phase_increment,
  input logic              out_song_running,
  input logic              out_last_channel
);

  `TES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `TES_ASSERT_NOW(a_busy_mid_tick, out_valid && !out_last_channel, !in_ready, "input taken mid tick")
  `TES_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && (in_func == FUNC_TICK), !in_ready, "tick not serialised")
  `TES_ASSERT_NOW(a_stopped_silent, out_valid && !out_song_running, out_phase_increment == '0, "stopped song reports increment")

endmodule

bind tone_event_sequencer_top tes_checker u_tes_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_func             (in_ch.func),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_phase_increment (out_ch.phase_increment),
  .out_song_running    (out_ch.song_running),
  .out_last_channel    (out_ch.last_channel)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tone event sequencer testbench
// Fills song memory, walks a directed table and then plays random songs with
// noise through the valid/ready channels under three idling mixes. A
// behavioural copy of the sequencer predicts per-channel results (typed rows
// give templates); each accepted one is checked field by field against the oldest due.
// ----------------------------------------------------------------------------
module tb_top;
  import tes_pkg::*;

  localparam int N_VOICES = CHANNELS_DEF;
  // func code 3 has no meaning: the block drops it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // opcode that matches neither register while they hold their reset values
  localparam logic [OPC_W-1:0] OPC_UNUSED_RST = 6'd63;
  // allow a margin after the last item before touching registers
  localparam int SETTLE_CYCLES = 16;
  // a tick may run the full event limit before it reports
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_TICKS = 100;
  localparam int ITEMS_PER_LEG = 70;

  typedef struct packed {
    logic [CHNUM_W-1:0]  chan;
    logic [VOL_W-1:0]    vol;
    logic [INCR_W-1:0]   incr;
    logic                restart;
    logic [FILTER_W-1:0] filt;
    logic                running;
    logic                last;
  } voice_report_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              typed;
    voice_report_t     want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  tes_in_if  in_ch ();
  tes_out_if out_ch ();

  tone_event_sequencer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Sequencer state as the predictor sees it
  logic [BYTE_W-1:0]   song_bytes    [SONG_DEPTH];
  logic [VOL_W-1:0]    env_start     [N_VOICES];
  logic [BYTE_W-1:0]   env_slope     [N_VOICES];
  logic [VOL_W-1:0]    voice_vol     [N_VOICES];
  logic [INCR_W-1:0]   voice_incr    [N_VOICES];
  logic                voice_restart [N_VOICES];
  logic [FILTER_W-1:0] filter_now;
  logic [7:0]          cue_time;
  logic [7:0]          beat;
  logic [ADDR_W-1:0]   cue_ptr;
  logic                playing;
  logic [OPC_W-1:0]    opc_envelope;
  logic [OPC_W-1:0]    opc_note;

  voice_report_t expected_reports [$];
  stim_row_t     directed_rows [$];

  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 85;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] next_song_byte();
    logic [BYTE_W-1:0] b;
    b = song_bytes[cue_ptr];
    cue_ptr = cue_ptr + 1'b1;  // wraps with the address width
    return b;
  endfunction

  // Run one 4-byte event: effect, parameter low, parameter high, delta
  function automatic void run_cue();
    logic [BYTE_W-1:0] effect;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] dt;
    int ch;
    int c;
    effect = next_song_byte();
    lo = next_song_byte();
    hi = next_song_byte();
    dt = next_song_byte();
    ch = effect[1:0];
    cue_time = cue_time + dt;
    // set envelope takes priority when both registers hold the same code
    if (effect[7:2] == opc_envelope) begin
      env_slope[ch] = hi;
      env_start[ch] = lo;
    end else if (effect[7:2] == opc_note) begin
      voice_vol[ch] = env_start[ch];
      filter_now = FILTER_NOTE;
      voice_incr[ch] = {hi, lo};
      voice_restart[ch] = 1'b1;
    end
    if (dt == END_DELTA) begin
      playing = 1'b0;
      for (c = 0; c < N_VOICES; c++) voice_incr[c] = '0;
    end
  endfunction

  function automatic void advance_tick();
    int c;
    int vol;
    int runs;
    for (c = 0; c < N_VOICES; c++) voice_restart[c] = 1'b0;
    if (playing) begin
      for (c = 0; c < N_VOICES; c++) begin
        if (int'(filter_now) + int'(FILTER_STEP) > int'(FILTER_MAX)) filter_now = FILTER_MAX;
        else filter_now = filter_now + FILTER_STEP;
        vol = int'(voice_vol[c]) + int'($signed(env_slope[c]));
        if (vol > 255) vol = 255;
        else if (vol < 0) vol = 0;
        voice_vol[c] = vol[VOL_W-1:0];
      end
      runs = 0;
      while (playing && cue_time == beat && runs < EVT_LIMIT) begin
        run_cue();
        runs++;
      end
      beat = beat + 1'b1;
    end
  endfunction

  // Apply one accepted item; a tick queues one report per channel, either
  // predicted or taken from a typed template
  function automatic void predict_item(input logic [FUNC_W-1:0] func,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data,
                                       input logic typed, input voice_report_t want);
    voice_report_t rep;
    int c;
    case (func)
      FUNC_LOAD: song_bytes[addr] = data;
      FUNC_START: begin
        cue_time = beat + song_bytes[addr];
        cue_ptr = addr + 1'b1;
        playing = 1'b1;
      end
      FUNC_TICK: begin
        advance_tick();
        for (c = 0; c < N_VOICES; c++) begin
          if (typed) begin
            rep = want;
          end else begin
            rep.vol = voice_vol[c];
            rep.incr = voice_incr[c];
            rep.restart = voice_restart[c];
            rep.filt = filter_now;
            rep.running = playing;
          end
          rep.chan = c;
          rep.last = (c == N_VOICES - 1);
          expected_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input int chan, input string name,
                               input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("channel %0d %s: got %0d, expected %0d", chan, name, got, want));
  endtask

  task automatic check_report();
    voice_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("channel %0d result with nothing expected",
                                out_ch.channel_number));
    end else begin
      want = expected_reports.pop_front();
      compare_field(want.chan, "channel_number", out_ch.channel_number, want.chan);
      compare_field(want.chan, "channel_volume", out_ch.channel_volume, want.vol);
      compare_field(want.chan, "phase_increment", out_ch.phase_increment, want.incr);
      compare_field(want.chan, "note_restart", out_ch.note_restart, want.restart);
      compare_field(want.chan, "filter_level", out_ch.filter_level, want.filt);
      compare_field(want.chan, "song_running", out_ch.song_running, want.running);
      compare_field(want.chan, "last_channel", out_ch.last_channel, want.last);
    end
  endtask

  // Sample results at the edge, then pick the next ready at random
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_report();
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Abort when neither channel has moved an item for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic typed,
                           input voice_report_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.song_address <= addr;
    in_ch.song_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(func, addr, data, typed, want);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  // Hold the sender until every result is in and the block has gone quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_opcodes(input logic [OPC_W-1:0] env, input logic [OPC_W-1:0] note);
    drain_results();
    wr_en <= 1'b1;
    wr_index <= CFG_SET_ENV;
    wr_data <= env;
    @(posedge clk);
    opc_envelope = env;
    wr_index <= CFG_PLAY_NOTE;
    wr_data <= note;
    @(posedge clk);
    opc_note = note;
    wr_en <= 1'b0;
  endtask

  // Stray item: dropped code, stray load, extra tick or a start anywhere
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0, 1: send_item(FUNC_UNUSED, $urandom_range(0, SONG_DEPTH - 1), $urandom_range(0, 255),
                      1'b0, '0);
      2, 3: send_item(FUNC_LOAD, $urandom_range(0, SONG_DEPTH - 1), $urandom_range(0, 255),
                      1'b0, '0);
      4: send_item(FUNC_TICK, $urandom_range(0, SONG_DEPTH - 1), $urandom_range(0, 255),
                   1'b0, '0);
      default: send_item(FUNC_START, $urandom_range(0, SONG_DEPTH - 1),
                         $urandom_range(0, 255), 1'b0, '0);
    endcase
  endtask

  // Build a song at a random base, load it, start it and tick it through.
  // A held song plays one note and then waits long enough for the filter
  // to climb back to its ceiling.
  task automatic play_song(input bit hold);
    logic [BYTE_W-1:0] song [$];
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] at;
    logic [OPC_W-1:0]  op;
    logic [1:0]        ch;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] dt;
    int n_cues;
    int k;
    int kind;
    int span;
    int ticks;
    base = $urandom_range(0, SONG_DEPTH - 1);
    n_cues = hold ? 2 : $urandom_range(1, 5);
    span = $urandom_range(0, 2);
    song.push_back(span);
    for (k = 0; k < n_cues; k++) begin
      ch = $urandom_range(0, 3);
      kind = hold ? (k == 0 ? 4 : 8) : $urandom_range(0, 9);
      if (kind < 4) op = opc_envelope;
      else if (kind < 8) op = opc_note;
      else if (kind == 8) begin
        do op = $urandom_range(0, 63); while (op == opc_envelope || op == opc_note);
      end else op = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: lo = 8'h00;
        1: lo = 8'hFF;
        default: lo = $urandom_range(0, 255);
      endcase
      // envelope slopes lean towards small steps either way and the sign edge
      if (kind < 4) begin
        case ($urandom_range(0, 3))
          0: hi = $urandom_range(1, 12);
          1: hi = 8'd0 - $urandom_range(1, 12);
          2: hi = $urandom_range(0, 1) ? 8'h7F : 8'h80;
          default: hi = $urandom_range(0, 255);
        endcase
      end else begin
        hi = $urandom_range(0, 255);
      end
      if (hold) begin
        dt = (k == 0) ? 8'd120 : END_DELTA;
      end else if (k == n_cues - 1) begin
        dt = ($urandom_range(0, 3) != 0) ? END_DELTA : $urandom_range(0, 2);
      end else begin
        case ($urandom_range(0, 19))
          0: dt = END_DELTA;
          1: dt = $urandom_range(3, 255);
          default: dt = $urandom_range(0, 2);
        endcase
      end
      if (dt != END_DELTA) span += dt;
      song.push_back({op, ch});
      song.push_back(lo);
      song.push_back(hi);
      song.push_back(dt);
    end

    at = base;
    foreach (song[k]) begin
      if (!hold && $urandom_range(0, 14) == 0) send_noise();
      send_item(FUNC_LOAD, at, song[k], 1'b0, '0);
      at = at + 1'b1;
    end
    // now and then let everything drain before the song starts
    if ($urandom_range(0, 29) == 0) drain_results();
    send_item(FUNC_START, base, $urandom_range(0, 255), 1'b0, '0);

    ticks = hold ? HOLD_TICKS : (span > 20 ? 20 : span) + $urandom_range(1, 3);
    for (k = 0; k < ticks; k++) begin
      if (!hold && $urandom_range(0, 9) == 0) send_noise();
      send_item(FUNC_TICK, $urandom_range(0, SONG_DEPTH - 1), $urandom_range(0, 255),
                1'b0, '0);
    end
  endtask

  // Directed row; typed rows carry one report template for every channel
  function automatic void add_row(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                                  input logic [BYTE_W-1:0] data, input logic typed,
                                  input logic [VOL_W-1:0] vol, input logic [INCR_W-1:0] incr,
                                  input logic [FILTER_W-1:0] filt, input logic running);
    stim_row_t r;
    r.func = func;
    r.addr = addr;
    r.data = data;
    r.typed = typed;
    r.want = '0;
    r.want.vol = vol;
    r.want.incr = incr;
    r.want.filt = filt;
    r.want.running = running;
    directed_rows.push_back(r);
  endfunction

  initial begin : stimulus
    int a;
    int c;
    int leg;
    stim_row_t r;

    // Drive every block input to a known value from time zero
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_SET_ENV;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_TICK;
    in_ch.song_address = '0;
    in_ch.song_byte = '0;
    out_ch.ready = 1'b0;

    // Predictor starts from the reset state
    for (c = 0; c < N_VOICES; c++) begin
      env_start[c] = '0;
      env_slope[c] = '0;
      voice_vol[c] = '0;
      voice_incr[c] = '0;
      voice_restart[c] = 1'b0;
    end
    filter_now = '0;
    cue_time = '0;
    beat = '0;
    cue_ptr = '0;
    playing = 1'b0;
    opc_envelope = OPC_SET_ENV_RST;
    opc_note = OPC_PLAY_NOTE_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Write every song byte once, all zero, so that no read ever lands on an
    // unwritten entry. A song started on this zero run is an endless chain
    // of zero-delta events, which is what drives the per-tick event limit.
    for (a = 0; a < SONG_DEPTH; a++) send_item(FUNC_LOAD, a, 8'h00, 1'b0, '0);

    // Directed part, run under the reset opcodes
    // idle tick straight after reset: everything zero, song stopped
    add_row(FUNC_TICK, 10'h000, 8'h00, 1'b1, 8'd0, 16'd0, 14'd0, 1'b0);
    // unused code with every field bit high: dropped
    add_row(FUNC_UNUSED, 10'h3FF, 8'hFF, 1'b0, '0, '0, '0, 1'b0);
    // start on the zero run: the first tick stops at the event limit having
    // only rewritten channel 0's envelope with zeros
    add_row(FUNC_START, 10'h200, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_TICK, 10'h000, 8'h00, 1'b1, 8'd0, 16'd0, 14'd32, 1'b1);
    add_row(FUNC_TICK, 10'h000, 8'h00, 1'b1, 8'd0, 16'd0, 14'd64, 1'b1);
    // song across the top of memory: envelope on channel 2, a note at full
    // increment, then an unknown-opcode event whose delta ends the song
    add_row(FUNC_LOAD, 10'h3FD, 8'd1, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h3FE, {OPC_SET_ENV_RST, 2'd2}, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h3FF, 8'd200, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h000, 8'hFC, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h001, 8'd0, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h002, {OPC_PLAY_NOTE_RST, 2'd2}, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h003, 8'hFF, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h004, 8'hFF, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h005, 8'd1, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h006, {OPC_UNUSED_RST, 2'd3}, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h007, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h008, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_LOAD, 10'h009, END_DELTA, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_START, 10'h3FD, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_TICK, 10'h155, 8'h55, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_TICK, 10'h2AA, 8'hAA, 1'b0, '0, '0, '0, 1'b0);
    add_row(FUNC_TICK, 10'h000, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    // stopped again: restart marks clear, tick time holds
    add_row(FUNC_TICK, 10'h000, 8'h00, 1'b0, '0, '0, '0, 1'b0);
    foreach (directed_rows[a]) begin
      r = directed_rows[a];
      send_item(r.func, r.addr, r.data, r.typed, r.want);
    end

    // Random songs in six legs: two per idling mix, each under its own
    // opcode pair (extremes, equal codes, random picks, back to reset)
    for (leg = 0; leg < 6; leg++) begin
      if (leg < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 85;
      end else if (leg < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (leg)
        0: set_opcodes(6'd63, 6'd0);
        1: set_opcodes(6'd7, 6'd7);
        3: set_opcodes(6'd0, 6'd63);
        5: set_opcodes(OPC_SET_ENV_RST, OPC_PLAY_NOTE_RST);
        default: set_opcodes($urandom_range(0, 63), $urandom_range(0, 63));
      endcase
      items_sent = 0;
      // one long note so that the filter reaches its ceiling
      if (leg == 4) play_song(1'b1);
      while (items_sent < ITEMS_PER_LEG) play_song(1'b0);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
